// File: rtl/line_editor_with_word_motion_unit_defines.svh
// Assertion macros shared by the line editor RTL.
`ifndef LINE_EDITOR_WITH_WORD_MOTION_UNIT_DEFINES_SVH
`define LINE_EDITOR_WITH_WORD_MOTION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LEWM_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define LEWM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/lewm_pkg.sv
// Shared types, codes and constants of the line editor.
package lewm_pkg;

    localparam int LINE_BUF_DEF = 64;
    localparam int QUEUE_DEPTH  = 2;
    localparam int OUT_DATA_W   = 24;

    localparam logic [1:0] OP_CHAR    = 2'd0;
    localparam logic [1:0] OP_PRESS   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_SUBMIT  = 2'd3;

    localparam logic [7:0] KEY_CTRL  = 8'd0;
    localparam logic [7:0] KEY_LEFT  = 8'd1;
    localparam logic [7:0] KEY_RIGHT = 8'd2;
    localparam logic [7:0] KEY_DEL   = 8'd3;
    localparam logic [7:0] KEY_BACK  = 8'd4;
    localparam logic [7:0] KEY_HOME  = 8'd5;
    localparam logic [7:0] KEY_END   = 8'd6;

    localparam logic [7:0] SPACE_CODE     = 8'd32;
    localparam logic [7:0] PRINTABLE_LAST = 8'd126;

    typedef enum logic [3:0] {
        CMD_IGNORE,
        CMD_INSERT,
        CMD_LEFT,
        CMD_RIGHT,
        CMD_WLEFT,
        CMD_WRIGHT,
        CMD_DEL,
        CMD_WDEL,
        CMD_BACK,
        CMD_WBACK,
        CMD_HOME,
        CMD_END,
        CMD_SUBMIT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] ch;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PUT,
        ST_SCAN,
        ST_REMOVE,
        ST_SUBMIT,
        ST_EMIT
    } back_state_t;

endpackage

// File: rtl/lewm_front.sv
// Input stage: accepts beats, tracks the control key and classifies commands.
module lewm_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // key_code
    input  logic [1:0]    s_tuser,   // opcode
    output logic          q_valid,
    input  logic          q_ready,
    output lewm_pkg::cmd_t q_cmd
);
    import lewm_pkg::*;

    logic ctrl_reg;
    logic ctrl_next;
    logic accept;

    assign s_tready = q_ready;
    assign q_valid  = s_tvalid;
    assign accept   = s_tvalid && q_ready;

    always_comb
    begin
        q_cmd.ch   = s_tdata;
        q_cmd.kind = CMD_IGNORE;
        ctrl_next  = ctrl_reg;
        unique case (s_tuser)
            OP_CHAR:
            begin
                if (s_tdata >= SPACE_CODE && s_tdata <= PRINTABLE_LAST)
                begin
                    q_cmd.kind = CMD_INSERT;
                end
            end
            OP_PRESS:
            begin
                priority case (s_tdata)
                    KEY_CTRL:  ctrl_next  = 1'b1;
                    KEY_LEFT:  q_cmd.kind = ctrl_reg ? CMD_WLEFT : CMD_LEFT;
                    KEY_RIGHT: q_cmd.kind = ctrl_reg ? CMD_WRIGHT : CMD_RIGHT;
                    KEY_DEL:   q_cmd.kind = ctrl_reg ? CMD_WDEL : CMD_DEL;
                    KEY_BACK:  q_cmd.kind = ctrl_reg ? CMD_WBACK : CMD_BACK;
                    KEY_HOME:  q_cmd.kind = CMD_HOME;
                    KEY_END:   q_cmd.kind = CMD_END;
                    default:   q_cmd.kind = CMD_IGNORE;
                endcase
            end
            OP_RELEASE:
            begin
                if (s_tdata == KEY_CTRL)
                begin
                    ctrl_next = 1'b0;
                end
            end
            OP_SUBMIT:
            begin
                q_cmd.kind = CMD_SUBMIT;
                ctrl_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= 1'b0;
        end
        else if (accept)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

endmodule

// File: rtl/lewm_queue.sv
// Short command queue between the input stage and the edit engine.
module lewm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  lewm_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output lewm_pkg::cmd_t pop_cmd
);
    import lewm_pkg::*;

`include "line_editor_with_word_motion_unit_defines.svh"

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_SLOT  = PW'(QUEUE_DEPTH - 1);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push;
    logic          pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    `LEWM_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_COUNT, "queue overfilled")

endmodule

// File: rtl/lewm_back.sv
// Edit engine: line memory, cursor and length, sequencer and result register.
module lewm_back #(
    parameter int LINE_BUF = lewm_pkg::LINE_BUF_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  lewm_pkg::cmd_t                  q_cmd,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lewm_pkg::OUT_DATA_W-1:0] m_tdata,  // consumed, cursor_pos, line_length, out_char
    output logic [0:0]                      m_tuser,  // char_valid
    output logic                            m_tlast
);
    import lewm_pkg::*;

`include "line_editor_with_word_motion_unit_defines.svh"

    localparam int AW = $clog2(LINE_BUF);
    localparam logic [AW-1:0] LEN_MAX = AW'(LINE_BUF - 1);

    logic [7:0]    mem [LINE_BUF];
    logic [7:0]    rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic [AW-1:0] rd_addr;

    back_state_t   state_reg, state_next;
    logic [AW-1:0] len_reg, len_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] p_reg, p_next;
    logic [AW-1:0] n_reg, n_next;
    logic [AW-1:0] subn_reg, subn_next;
    logic          pend_reg, pend_next;
    logic          phase_reg, phase_next;
    logic          sp_reg, sp_next;
    cmd_kind_t     kind_reg, kind_next;
    logic [7:0]    ch_reg, ch_next;
    logic          consumed_reg, consumed_next;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_user_reg;
    logic                  out_last_reg;
    logic                  out_free;
    logic                  out_load;
    logic [7:0]            ld_char;
    logic                  ld_valid;
    logic                  ld_last;

    logic          is_left;
    logic          is_del;
    logic          at_bound;
    logic          blank;
    logic          do_step;
    logic          scan_done;
    logic [AW-1:0] p_step;
    logic [AW-1:0] ex_addr;
    logic [AW-1:0] step_addr;
    logic [AW-1:0] sh_j;
    logic [AW-1:0] rm_j;
    logic [AW:0]   rm_sum;
    logic [AW+5:0] cur_ext;
    logic [AW+5:0] len_ext;

    assign out_free  = !out_valid_reg || m_tready;
    assign is_left   = (kind_reg == CMD_WLEFT) || (kind_reg == CMD_WBACK);
    assign is_del    = (kind_reg == CMD_WDEL) || (kind_reg == CMD_WBACK);
    assign at_bound  = is_left ? (p_reg == '0) : (p_reg == len_reg);
    assign blank     = (rdata_reg == SPACE_CODE);
    assign p_step    = is_left ? p_reg - AW'(1) : p_reg + AW'(1);
    assign ex_addr   = is_left ? p_reg - AW'(1) : p_reg;
    assign step_addr = is_left ? p_reg - AW'(2) : p_reg + AW'(1);
    assign sh_j      = pend_reg ? p_reg - AW'(1) : p_reg;
    assign rm_j      = pend_reg ? p_reg + AW'(1) : p_reg;
    assign rm_sum    = {1'b0, rm_j} + {1'b0, n_reg};
    assign cur_ext   = {6'd0, cur_reg};
    assign len_ext   = {6'd0, len_reg};
    assign q_ready   = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        cur_next      = cur_reg;
        p_next        = p_reg;
        n_next        = n_reg;
        subn_next     = subn_reg;
        pend_next     = pend_reg;
        phase_next    = phase_reg;
        sp_next       = sp_reg;
        kind_next     = kind_reg;
        ch_next       = ch_reg;
        consumed_next = consumed_reg;
        mem_we        = 1'b0;
        mem_wa        = p_reg;
        mem_wd        = rdata_reg;
        rd_addr       = p_reg;
        out_load      = 1'b0;
        ld_char       = '0;
        ld_valid      = 1'b0;
        ld_last       = 1'b1;
        do_step       = 1'b0;
        scan_done     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    kind_next     = q_cmd.kind;
                    ch_next       = q_cmd.ch;
                    consumed_next = (q_cmd.kind != CMD_IGNORE);
                    p_next        = cur_reg;
                    pend_next     = 1'b0;
                    phase_next    = 1'b0;
                    state_next    = ST_EMIT;
                    unique case (q_cmd.kind)
                        CMD_IGNORE: ;
                        CMD_INSERT:
                        begin
                            if (len_reg < LEN_MAX)
                            begin
                                p_next     = len_reg;
                                state_next = ST_SHIFT;
                            end
                        end
                        CMD_LEFT:
                        begin
                            if (cur_reg != '0)
                            begin
                                cur_next = cur_reg - AW'(1);
                            end
                        end
                        CMD_RIGHT:
                        begin
                            if (cur_reg != len_reg)
                            begin
                                cur_next = cur_reg + AW'(1);
                            end
                        end
                        CMD_WLEFT, CMD_WRIGHT, CMD_WDEL, CMD_WBACK:
                        begin
                            state_next = ST_SCAN;
                        end
                        CMD_DEL:
                        begin
                            if (cur_reg != len_reg)
                            begin
                                n_next     = AW'(1);
                                state_next = ST_REMOVE;
                            end
                        end
                        CMD_BACK:
                        begin
                            if (cur_reg != '0)
                            begin
                                cur_next   = cur_reg - AW'(1);
                                p_next     = cur_reg - AW'(1);
                                n_next     = AW'(1);
                                state_next = ST_REMOVE;
                            end
                        end
                        CMD_HOME: cur_next = '0;
                        CMD_END:  cur_next = len_reg;
                        CMD_SUBMIT:
                        begin
                            subn_next = len_reg;
                            len_next  = '0;
                            cur_next  = '0;
                            p_next    = '0;
                            if (len_reg != '0)
                            begin
                                state_next = ST_SUBMIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = p_reg;
                    mem_wd = rdata_reg;
                end
                p_next = sh_j;
                if (sh_j > cur_reg)
                begin
                    rd_addr   = sh_j - AW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                mem_we     = 1'b1;
                mem_wa     = cur_reg;
                mem_wd     = ch_reg;
                cur_next   = cur_reg + AW'(1);
                len_next   = len_reg + AW'(1);
                state_next = ST_EMIT;
            end
            ST_SCAN:
            begin
                if (at_bound)
                begin
                    scan_done = 1'b1;
                end
                else if (!pend_reg)
                begin
                    rd_addr   = ex_addr;
                    pend_next = 1'b1;
                end
                else
                begin
                    rd_addr = ex_addr;
                    if (is_del)
                    begin
                        if (!phase_reg)
                        begin
                            sp_next    = blank;
                            phase_next = 1'b1;
                            do_step    = 1'b1;
                        end
                        else if (blank == sp_reg)
                        begin
                            do_step = 1'b1;
                        end
                        else
                        begin
                            scan_done = 1'b1;
                        end
                    end
                    else
                    begin
                        if (!phase_reg)
                        begin
                            if (blank)
                            begin
                                do_step = 1'b1;
                            end
                            else
                            begin
                                phase_next = 1'b1;
                            end
                        end
                        else if (!blank)
                        begin
                            do_step = 1'b1;
                        end
                        else
                        begin
                            scan_done = 1'b1;
                        end
                    end
                    if (do_step)
                    begin
                        p_next  = p_step;
                        rd_addr = step_addr;
                    end
                end
                if (scan_done)
                begin
                    pend_next = 1'b0;
                    if (!is_del)
                    begin
                        cur_next   = p_reg;
                        state_next = ST_EMIT;
                    end
                    else if (kind_reg == CMD_WDEL)
                    begin
                        n_next     = p_reg - cur_reg;
                        p_next     = cur_reg;
                        state_next = (p_reg == cur_reg) ? ST_EMIT : ST_REMOVE;
                    end
                    else
                    begin
                        n_next     = cur_reg - p_reg;
                        cur_next   = p_reg;
                        state_next = (p_reg == cur_reg) ? ST_EMIT : ST_REMOVE;
                    end
                end
            end
            ST_REMOVE:
            begin
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = p_reg;
                    mem_wd = rdata_reg;
                end
                p_next = rm_j;
                if (rm_sum < {1'b0, len_reg})
                begin
                    rd_addr   = rm_sum[AW-1:0];
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    len_next   = len_reg - n_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_SUBMIT:
            begin
                if (!pend_reg)
                begin
                    pend_next = 1'b1;
                end
                else if (out_free)
                begin
                    out_load = 1'b1;
                    ld_char  = rdata_reg;
                    ld_valid = 1'b1;
                    ld_last  = (p_reg == subn_reg - AW'(1));
                    if (ld_last)
                    begin
                        pend_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        p_next  = p_reg + AW'(1);
                        rd_addr = p_reg + AW'(1);
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            cur_reg       <= '0;
            p_reg         <= '0;
            n_reg         <= '0;
            subn_reg      <= '0;
            pend_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            sp_reg        <= 1'b0;
            kind_reg      <= CMD_IGNORE;
            consumed_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            cur_reg      <= cur_next;
            p_reg        <= p_next;
            n_reg        <= n_next;
            subn_reg     <= subn_next;
            pend_reg     <= pend_next;
            phase_reg    <= phase_next;
            sp_reg       <= sp_next;
            kind_reg     <= kind_next;
            consumed_reg <= consumed_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
        if (out_load)
        begin
            out_data_reg <= {3'd0, ld_char, len_ext[5:0], cur_ext[5:0], consumed_reg};
            out_user_reg <= ld_valid;
            out_last_reg <= ld_last;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_user_reg;
    assign m_tlast    = out_last_reg;

    `LEWM_ASSERT_IMPL(a_cur_in_line, clk, rst_n, 1'b1, cur_reg <= len_reg, "cursor past line end")
    `LEWM_ASSERT_IMPL(a_len_bound, clk, rst_n, 1'b1, len_reg <= LEN_MAX, "line length overflow")
    `LEWM_ASSERT_NEXT(a_submit_clear, clk, rst_n, state_reg == ST_SUBMIT,
        len_reg == '0 && cur_reg == '0, "line not cleared during submit")

endmodule

// File: rtl/line_editor_with_word_motion_unit.sv
// Top level of the single-line editor with word motion.
// One item is taken at a time. A key item, an ignored item or a submit of an empty line gives
// one result beat once the output is free. An insert that fits first moves each character
// right of the cursor up by one. Word motion walks the line one character at a time. A delete
// or backspace that removes a character moves the characters behind it down. A word delete or
// backspace scans the characters to remove and then moves the rest of the line down. A submit
// streams the line one character per cycle while the sink is ready. The line memory has a
// single read port and a single write port, and every shift and scan walks it one entry per
// cycle. The line memory needs no clearing pass after reset. Results leave through a
// registered output stage, and a two-entry command queue lets new beats in while the engine
// works.
module line_editor_with_word_motion_unit #(
    parameter int LINE_BUF = lewm_pkg::LINE_BUF_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // key_code
    input  logic [1:0]                      s_tuser,  // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lewm_pkg::OUT_DATA_W-1:0] m_tdata,  // consumed, cursor_pos, line_length, out_char
    output logic [0:0]                      m_tuser,  // char_valid
    output logic                            m_tlast
);
    import lewm_pkg::*;

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic front_valid;
    logic front_ready;
    logic back_valid;
    logic back_ready;

    lewm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (front_valid),
        .q_ready  (front_ready),
        .q_cmd    (front_cmd)
    );

    lewm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_cmd    (back_cmd)
    );

    lewm_back #(
        .LINE_BUF (LINE_BUF)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (back_valid),
        .q_ready  (back_ready),
        .q_cmd    (back_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
